// ----- rtl/s2c_pkg.sv -----
// shared constants and month table for the seconds to calendar converter
package s2c_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerQuad = 1461;

  // reciprocals: floor(x / d) = (x * m) >> k over the stated input range
  localparam logic [25:0] DayRecip  = 26'd50903317;  // (count >> 7) / 675, k = 35
  localparam logic [16:0] QuadRecip = 17'd91868;     // days / 1461, k = 27
  localparam logic [13:0] HourRecip = 14'd9321;      // (sod >> 4) / 225, k = 21
  localparam logic [10:0] MinRecip  = 11'd1093;      // (rem >> 2) / 15, k = 14

  // year 1970 minus 2000, modulo 256
  localparam logic [7:0] EpochYearOffset = 8'd226;

  localparam int unsigned OutDataWidth = 40;

  // days before the first of month index mon (0 is january)
  function automatic logic [8:0] days_before_month(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    begin
      case (mon)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && mon >= 4'd2) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// ----- rtl/seconds_to_calendar_core.sv -----
// seconds since 1970 to calendar date and time, six stage pipeline
//
// Takes one item per clock while the output side accepts; the pipeline holds every
// stage while the output item waits for tready, so tready on the input follows the
// output side. Days and time of day come from reciprocal multiplies with an exact
// remainder, years from four-year cycles of 1461 days (every year divisible by four
// is leap, 2100 included), months from a cumulative day table. Output year is
// calendar year minus 2000, modulo 256.
module seconds_to_calendar_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // seconds_count
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // year_offset[7:0], month_number[11:8], day_of_month[16:12], hour_of_day[21:17],
  // minute_of_hour[27:22], second_of_minute[33:28], zero fill
  output logic [s2c_pkg::OutDataWidth-1:0]   m_axis_tdata
);
  import s2c_pkg::*;

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic [31:0] cnt1;
  logic [50:0] pd1;
  // stage 2
  logic [15:0] days2;
  logic [16:0] sod2;
  // stage 3
  logic [32:0] pc3;
  logic [26:0] ph3;
  logic [15:0] days3;
  logic [16:0] sod3;
  // stage 4
  logic [5:0]  cyc4;
  logic [10:0] d4;
  logic [4:0]  hour4;
  logic [11:0] rem4;
  // stage 5
  logic [7:0]  yoff5;
  logic [8:0]  doy5;
  logic        leap5;
  logic [20:0] pm5;
  logic [4:0]  hour5;
  logic [11:0] rem5;
  // stage 6
  logic [7:0]  yoff6;
  logic [3:0]  mon6;
  logic [4:0]  day6;
  logic [4:0]  hour6;
  logic [5:0]  min6;
  logic [5:0]  sec6;

  // combinational
  logic [15:0] days2_next;
  logic [32:0] daysec2;
  logic [16:0] sod2_next;
  logic [5:0]  cyc4_next;
  logic [16:0] quadday4;
  logic [10:0] d4_next;
  logic [4:0]  hour4_next;
  logic [16:0] hoursec4;
  logic [11:0] rem4_next;
  logic [1:0]  yi5;
  logic [8:0]  doy5_next;
  logic        leap5_next;
  logic [7:0]  yoff5_next;
  logic [3:0]  mon6_next;
  logic [8:0]  dayidx6;
  logic [4:0]  day6_next;
  logic [5:0]  min6_next;
  logic [11:0] minsec6;
  logic [5:0]  sec6_next;

  assign en            = !v6 || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // whole days and seconds of the day
  assign days2_next = pd1[50:35];
  assign daysec2    = {17'd0, days2_next} * 33'(SecsPerDay);
  assign sod2_next  = cnt1[16:0] - daysec2[16:0];

  // four-year cycles and hour
  assign cyc4_next  = pc3[32:27];
  assign quadday4   = {11'd0, cyc4_next} * 17'(DaysPerQuad);
  assign d4_next    = days3[10:0] - quadday4[10:0];
  assign hour4_next = ph3[25:21];
  assign hoursec4   = {12'd0, hour4_next} * 17'(SecsPerHour);
  assign rem4_next  = sod3[11:0] - hoursec4[11:0];

  // year within the cycle: 1970 + 4n is followed by one leap year at index two
  always_comb begin
    if (d4 < 11'd365) begin
      yi5        = 2'd0;
      doy5_next  = d4[8:0];
      leap5_next = 1'b0;
    end else if (d4 < 11'd730) begin
      yi5        = 2'd1;
      doy5_next  = 9'(d4 - 11'd365);
      leap5_next = 1'b0;
    end else if (d4 < 11'd1096) begin
      yi5        = 2'd2;
      doy5_next  = 9'(d4 - 11'd730);
      leap5_next = 1'b1;
    end else begin
      yi5        = 2'd3;
      doy5_next  = 9'(d4 - 11'd1096);
      leap5_next = 1'b0;
    end
  end

  assign yoff5_next = {cyc4, yi5} + EpochYearOffset;

  // month by parallel compares against the cumulative table
  always_comb begin
    mon6_next = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy5 >= days_before_month(4'(k), leap5)) begin
        mon6_next = 4'(k);
      end
    end
  end

  assign dayidx6   = doy5 - days_before_month(mon6_next, leap5);
  assign day6_next = dayidx6[4:0] + 5'd1;
  assign min6_next = pm5[19:14];
  assign minsec6   = {6'd0, min6_next} * 12'(SecsPerMin);
  assign sec6_next = 6'(rem5 - minsec6);

  always_ff @(posedge clk) begin
    if (en) begin
      cnt1  <= s_axis_tdata;
      pd1   <= {26'd0, s_axis_tdata[31:7]} * {25'd0, DayRecip};

      days2 <= days2_next;
      sod2  <= sod2_next;

      pc3   <= {17'd0, days2} * {16'd0, QuadRecip};
      ph3   <= {14'd0, sod2[16:4]} * {13'd0, HourRecip};
      days3 <= days2;
      sod3  <= sod2;

      cyc4  <= cyc4_next;
      d4    <= d4_next;
      hour4 <= hour4_next;
      rem4  <= rem4_next;

      yoff5 <= yoff5_next;
      doy5  <= doy5_next;
      leap5 <= leap5_next;
      pm5   <= {11'd0, rem4[11:2]} * {10'd0, MinRecip};
      hour5 <= hour4;
      rem5  <= rem4;

      yoff6 <= yoff5;
      mon6  <= mon6_next;
      day6  <= day6_next;
      hour6 <= hour5;
      min6  <= min6_next;
      sec6  <= sec6_next;
    end
  end

  assign m_axis_tvalid = v6;
  assign m_axis_tdata  = {6'd0, sec6, min6, hour6, day6, mon6 + 4'd1, yoff6};

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:8] >= 4'd1 && m_axis_tdata[11:8] <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:12] >= 5'd1))
    else $error("day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (hour6 < 5'd24 && min6 < 6'd60 && sec6 < 6'd60))
    else $error("time of day out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v5 && v6 && !m_axis_tready) |=> v5)
    else $error("pipeline item lost during stall");

endmodule
